>>> src/lldr_pkg.sv
package lldr_pkg;

    localparam int LABEL_W  = 16;
    localparam int CNT_W    = 4;
    localparam int MODE_W   = 2;
    localparam int KIND_W   = 2;
    localparam int DATA_W   = 3 * LABEL_W;
    localparam int ENTRY_W  = 1 + CNT_W + LABEL_W;
    localparam int RUN_LIMIT = 64;
    localparam int SPAN_W   = $clog2(RUN_LIMIT + 1);

    localparam logic [LABEL_W-1:0] LABEL_RESET = 16'd1;
    localparam logic [CNT_W-1:0]   MAX_RTX_RESET = 4'd3;

    localparam logic [MODE_W-1:0] MODE_SEND   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RECV   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NOTIFY = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESET  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_LABEL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOSS  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RETX  = 2'd2;

    typedef struct packed {
        logic capture;
        logic clr_start;
        logic clr_step;
        logic send;
        logic recv;
        logic mod_start;
        logic mod_step;
        logic rd;
        logic eval;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic skip;
        logic mod_done;
        logic hit;
        logic out_free;
        logic pend_valid;
        logic run_last;
        logic recv_emit;
    } t_status;

endpackage

>>> src/lldr_ram.sv
module lldr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/lldr_ctrl.sv
module lldr_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    input  logic [lldr_pkg::MODE_W-1:0]  i_mode,
    output logic                         o_s_tready,
    input  lldr_pkg::t_status            i_status,
    output lldr_pkg::t_cmd               o_cmd
);
    import lldr_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_SEND  = 4'd2;
    localparam logic [3:0] S_RECV  = 4'd3;
    localparam logic [3:0] S_CHECK = 4'd4;
    localparam logic [3:0] S_MOD   = 4'd5;
    localparam logic [3:0] S_READ  = 4'd6;
    localparam logic [3:0] S_EVAL  = 4'd7;
    localparam logic [3:0] S_FLUSH = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       w_accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.capture = 1'b1;
                    case (i_mode)
                        MODE_SEND:   n_state = S_SEND;
                        MODE_RECV:   n_state = S_RECV;
                        MODE_NOTIFY: n_state = S_CHECK;
                        MODE_RESET: begin
                            o_cmd.clr_start = 1'b1;
                            n_state = S_CLEAR;
                        end
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_SEND: begin
                if (i_status.out_free) begin
                    o_cmd.send = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RECV: begin
                if (!i_status.recv_emit || i_status.out_free) begin
                    o_cmd.recv = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CHECK: begin
                if (i_status.skip) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.mod_start = 1'b1;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_status.mod_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                // A hit with a held result pushes that result out, so it waits for room.
                if (!(i_status.hit && i_status.pend_valid && !i_status.out_free)) begin
                    o_cmd.eval = 1'b1;
                    n_state = i_status.run_last ? S_FLUSH : S_READ;
                end
            end
            S_FLUSH: begin
                if (!i_status.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> src/lldr_dp.sv
module lldr_dp #(
    parameter int RING_DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lldr_pkg::t_cmd               i_cmd,
    output lldr_pkg::t_status            o_status,
    input  logic [lldr_pkg::DATA_W-1:0]  i_s_tdata,
    input  logic                         i_cfg_valid,
    input  logic [lldr_pkg::CNT_W-1:0]   i_cfg_data,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [lldr_pkg::DATA_W-1:0]  o_m_tdata,
    output logic [lldr_pkg::KIND_W-1:0]  o_m_tuser,
    output logic                         o_m_tlast
);
    import lldr_pkg::*;

    localparam int SLOT_W = $clog2(RING_DEPTH);
    localparam int SPAN_LIMIT = (RING_DEPTH < RUN_LIMIT) ? RING_DEPTH : RUN_LIMIT;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);
    localparam logic [SLOT_W:0]   DEPTH_EXT = (SLOT_W + 1)'(RING_DEPTH);
    localparam logic [LABEL_W-1:0] DEPTH_LABEL = LABEL_W'(RING_DEPTH);
    // Scaled reciprocal of the ring depth; the quotient it gives is exact or one short.
    localparam logic [31:0] MOD_RECIP = 32'((64'd1 << 32) / 64'(RING_DEPTH));

    // Captured request fields.
    logic [LABEL_W-1:0] r_handle;
    logic [LABEL_W-1:0] r_label;
    logic [LABEL_W-1:0] r_rlabel;

    logic [LABEL_W-1:0] r_next_tx;
    logic [SLOT_W-1:0]  r_tx_slot;
    logic [LABEL_W-1:0] r_exp;
    logic [CNT_W-1:0]   r_max_rtx;
    logic [SLOT_W-1:0]  r_clr_addr;

    // Label-to-slot remainder by reciprocal multiplication, then a correction step; the
    // remainder then walks the ring as the read slot.
    logic [LABEL_W-1:0]     r_mod_q;
    logic                   r_mod_cnt;
    logic [SLOT_W:0]        r_mod_est;
    logic [SLOT_W-1:0]      r_rd_slot;
    logic [SPAN_W-1:0]      r_span;

    // Held result and output register.
    logic                r_pend_valid;
    logic [KIND_W-1:0]   r_pend_kind;
    logic [DATA_W-1:0]   r_pend_data;
    logic                r_out_valid;
    logic [KIND_W-1:0]   r_out_kind;
    logic [DATA_W-1:0]   r_out_data;
    logic                r_out_last;

    logic                w_out_free;
    logic [LABEL_W+31:0] w_mod_prod;
    logic [LABEL_W-1:0]  w_mod_qd;
    logic [LABEL_W-1:0]  w_mod_diff;
    logic                w_mod_ge;
    logic [SLOT_W-1:0]   w_mod_rem;
    logic signed [LABEL_W+1:0] w_diff;
    logic                w_skip;
    logic [LABEL_W-1:0]  w_span_raw;
    logic [SPAN_W-1:0]   w_span;
    logic                w_recv_emit;
    logic [ENTRY_W-1:0]  w_rdata;
    logic                w_rd_valid;
    logic [CNT_W-1:0]    w_rd_cnt;
    logic [LABEL_W-1:0]  w_rd_handle;
    logic                w_hit;
    logic                w_we;
    logic [SLOT_W-1:0]   w_waddr;
    logic [ENTRY_W-1:0]  w_wdata;
    logic                w_tx_adv;
    logic [SLOT_W-1:0]   w_tx_slot_inc;

    assign w_out_free = !r_out_valid || i_m_tready;

    assign w_diff = $signed({2'b00, r_next_tx}) - $signed({2'b00, r_label});
    assign w_skip = (w_diff > $signed((LABEL_W + 2)'(RING_DEPTH))) || (r_rlabel <= r_label);

    assign w_span_raw = r_rlabel - r_label;
    assign w_span = (w_span_raw > LABEL_W'(SPAN_LIMIT)) ? SPAN_W'(SPAN_LIMIT)
                                                         : w_span_raw[SPAN_W-1:0];

    // The estimated quotient never exceeds the true one, so the product fits the label
    // width and the first remainder is below twice the depth.
    assign w_mod_prod = {32'b0, r_label} * {{LABEL_W{1'b0}}, MOD_RECIP};
    assign w_mod_qd   = r_mod_q * DEPTH_LABEL;
    assign w_mod_diff = r_label - w_mod_qd;
    assign w_mod_ge   = (r_mod_est >= DEPTH_EXT);
    assign w_mod_rem  = w_mod_ge ? SLOT_W'(r_mod_est - DEPTH_EXT) : r_mod_est[SLOT_W-1:0];

    assign w_recv_emit = (r_label != r_exp) && ((r_label != LABEL_RESET) || (r_exp == '0));

    assign w_rd_valid  = w_rdata[ENTRY_W-1];
    assign w_rd_cnt    = w_rdata[ENTRY_W-2 -: CNT_W];
    assign w_rd_handle = w_rdata[LABEL_W-1:0];
    assign w_hit       = w_rd_valid && (w_rd_cnt < r_max_rtx);

    assign w_tx_adv = i_cmd.send || (i_cmd.eval && w_hit);
    assign w_tx_slot_inc = (r_next_tx == {LABEL_W{1'b1}}) ? '0 :
                           (r_tx_slot == LAST_SLOT) ? '0 : r_tx_slot + 1'b1;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_tx_slot;
        w_wdata = '0;
        if (i_cmd.clr_step) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
        end else if (i_cmd.send) begin
            w_we    = 1'b1;
            w_wdata = {1'b1, {CNT_W{1'b0}}, r_handle};
        end else if (i_cmd.eval && w_hit) begin
            w_we    = 1'b1;
            w_wdata = {1'b1, w_rd_cnt + 1'b1, w_rd_handle};
        end
    end

    lldr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_rd_slot),
        .o_rdata (w_rdata)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_tx    <= LABEL_RESET;
            r_tx_slot    <= SLOT_W'(1);
            r_exp        <= LABEL_RESET;
            r_max_rtx    <= MAX_RTX_RESET;
            r_clr_addr   <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max_rtx <= i_cfg_data;
            end
            if (i_cmd.clr_start) begin
                r_next_tx  <= LABEL_RESET;
                r_tx_slot  <= SLOT_W'(1);
                r_exp      <= LABEL_RESET;
                r_clr_addr <= '0;
            end else if (w_tx_adv) begin
                r_next_tx <= r_next_tx + 1'b1;
                r_tx_slot <= w_tx_slot_inc;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.recv) begin
                r_exp <= r_label + 1'b1;
            end
            if (i_cmd.eval && w_hit) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.send || (i_cmd.recv && w_recv_emit) || i_cmd.flush ||
                (i_cmd.eval && w_hit && r_pend_valid)) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_handle <= i_s_tdata[LABEL_W-1:0];
            r_label  <= i_s_tdata[2*LABEL_W-1:LABEL_W];
            r_rlabel <= i_s_tdata[3*LABEL_W-1:2*LABEL_W];
        end
        if (i_cmd.mod_start) begin
            r_mod_q   <= w_mod_prod[LABEL_W+31:32];
            r_mod_cnt <= 1'b0;
            r_span    <= w_span;
        end else if (i_cmd.mod_step) begin
            r_mod_cnt <= 1'b1;
            if (!r_mod_cnt) begin
                r_mod_est <= w_mod_diff[SLOT_W:0];
            end else begin
                r_rd_slot <= w_mod_rem;
            end
        end else if (i_cmd.eval) begin
            r_rd_slot <= (r_rd_slot == LAST_SLOT) ? '0 : r_rd_slot + 1'b1;
            r_span    <= r_span - 1'b1;
        end
        if (i_cmd.eval && w_hit) begin
            r_pend_kind <= KIND_RETX;
            r_pend_data <= {{LABEL_W{1'b0}}, r_next_tx, w_rd_handle};
        end
        if (i_cmd.send) begin
            r_out_kind <= KIND_LABEL;
            r_out_data <= {{LABEL_W{1'b0}}, r_next_tx, r_handle};
            r_out_last <= 1'b1;
        end else if (i_cmd.recv && w_recv_emit) begin
            r_out_kind <= KIND_LOSS;
            r_out_data <= {r_label, r_exp, r_handle};
            r_out_last <= 1'b1;
        end else if (i_cmd.flush) begin
            r_out_kind <= r_pend_kind;
            r_out_data <= r_pend_data;
            r_out_last <= 1'b1;
        end else if (i_cmd.eval && w_hit && r_pend_valid) begin
            r_out_kind <= r_pend_kind;
            r_out_data <= r_pend_data;
            r_out_last <= 1'b0;
        end
    end

    always_comb begin
        o_status            = '0;
        o_status.clr_last   = (r_clr_addr == LAST_SLOT);
        o_status.skip       = w_skip;
        o_status.mod_done   = r_mod_cnt;
        o_status.hit        = w_hit;
        o_status.out_free   = w_out_free;
        o_status.pend_valid = r_pend_valid;
        o_status.run_last   = (r_span == SPAN_W'(1));
        o_status.recv_emit  = w_recv_emit;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

endmodule

>>> src/link_loss_detect_retransmit_top.sv
// A send request is accepted, then, once the output has room, advances the label registers,
// writes the ring slot and loads the output register. A receive request updates the expected
// label and on a loss waits for room and loads the output register. A notification that is
// not stale or empty finds the label-to-slot remainder by reciprocal multiply, then reads
// each slot in its range, evaluates and rewrites it, and releases the last resend. Only one
// request is in work at a time. Reset and the reset mode clear the ring one slot a cycle.
module link_loss_detect_retransmit_top #(
    parameter int RING_DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Request stream.
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // packet_handle [15:0], packet_label [31:16], last_received_label [47:32]
    input  logic [lldr_pkg::DATA_W-1:0]  i_s_tdata,
    // mode [1:0]
    input  logic [lldr_pkg::MODE_W-1:0]  i_s_tuser,
    // Result stream.
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // out_handle [15:0], out_label [31:16], out_received_label [47:32]
    output logic [lldr_pkg::DATA_W-1:0]  o_m_tdata,
    // result_kind [1:0]
    output logic [lldr_pkg::KIND_W-1:0]  o_m_tuser,
    // last_of_run
    output logic                         o_m_tlast,
    // Configuration: max_retransmissions.
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [lldr_pkg::CNT_W-1:0]   i_cfg_data
);
    import lldr_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // The register may be written at any time the block is idle, so the
    // configuration channel is always ready.
    assign o_cfg_ready = 1'b1;

    // The controller sequences each request: it dispatches on the mode, walks
    // the notification range one slot at a time and waits on output backpressure.
    lldr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_mode     (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the labels, the ring memory, the remainder unit, and a
    // held result so that the final result of a run can be marked as last.
    lldr_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

>>> bench/lldr_label_checker.sv
`timescale 1ns / 100ps

module lldr_label_checker #(
    parameter int RING_DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    input  logic                         i_s_tready,
    input  logic [lldr_pkg::DATA_W-1:0]  i_s_tdata,
    input  logic [lldr_pkg::MODE_W-1:0]  i_s_tuser,
    input  logic                         i_m_tvalid,
    input  logic                         i_m_tready,
    input  logic [lldr_pkg::DATA_W-1:0]  i_m_tdata,
    input  logic [lldr_pkg::KIND_W-1:0]  i_m_tuser,
    input  logic                         i_m_tlast,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [lldr_pkg::CNT_W-1:0]   i_cfg_data,
    output int                           o_mismatches,
    output int                           o_outstanding
);
    import lldr_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [LABEL_W-1:0] handle;
        logic [LABEL_W-1:0] label;
        logic [LABEL_W-1:0] rx_label;
        logic               last;
    } t_link_result;

    // A notification never walks more slots than the ring holds.
    localparam int WALK_MAX = (RING_DEPTH < RUN_LIMIT) ? RING_DEPTH : RUN_LIMIT;

    logic [LABEL_W-1:0] rx_expect;
    logic [LABEL_W-1:0] tx_next;
    logic               ring_valid  [RING_DEPTH];
    logic [LABEL_W-1:0] ring_handle [RING_DEPTH];
    logic [CNT_W-1:0]   ring_tries  [RING_DEPTH];
    logic [CNT_W-1:0]   rtx_limit;
    t_link_result       due_results [$];
    int                 mismatch_count = 0;
    int                 waiting_count = 0;

    assign o_mismatches  = mismatch_count;
    assign o_outstanding = waiting_count;

    function automatic int slot_of(logic [LABEL_W-1:0] lab);
        return int'(lab) % RING_DEPTH;
    endfunction

    task automatic clear_link();
        rx_expect = LABEL_RESET;
        tx_next   = LABEL_RESET;
        for (int i = 0; i < RING_DEPTH; i++) begin
            ring_valid[i] = 1'b0;
            ring_tries[i] = '0;
        end
    endtask

    task automatic predict_request(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] data);
        logic [LABEL_W-1:0] handle, label, rx_label, lab, h;
        logic [CNT_W-1:0]   c;
        t_link_result       run [$];
        int                 span, s, d;
        handle   = data[LABEL_W-1:0];
        label    = data[2*LABEL_W-1:LABEL_W];
        rx_label = data[3*LABEL_W-1:2*LABEL_W];
        case (mode)
            MODE_SEND: begin
                s = slot_of(tx_next);
                ring_valid[s]  = 1'b1;
                ring_handle[s] = handle;
                ring_tries[s]  = '0;
                run.push_back('{KIND_LABEL, handle, tx_next, '0, 1'b0});
                tx_next = tx_next + 1'b1;
            end
            MODE_RECV: begin
                if (label != rx_expect) begin
                    // A jump back to the first label is a resync, not a loss,
                    // unless the receiver had wrapped to label zero.
                    if (label != LABEL_RESET || rx_expect == '0)
                        run.push_back('{KIND_LOSS, handle, rx_expect, label, 1'b0});
                    rx_expect = label + 1'b1;
                end else begin
                    rx_expect = rx_expect + 1'b1;
                end
            end
            MODE_NOTIFY: begin
                // Stale ranges compare as plain integers, without wrap.
                if (int'(tx_next) - int'(label) <= RING_DEPTH && rx_label > label) begin
                    span = int'(rx_label) - int'(label);
                    if (span > WALK_MAX)
                        span = WALK_MAX;
                    for (int i = 0; i < span; i++) begin
                        lab = label + LABEL_W'(i);
                        s = slot_of(lab);
                        if (ring_valid[s] && ring_tries[s] < rtx_limit) begin
                            h = ring_handle[s];
                            c = ring_tries[s] + 1'b1;
                            d = slot_of(tx_next);
                            ring_valid[d]  = 1'b1;
                            ring_handle[d] = h;
                            ring_tries[d]  = c;
                            run.push_back('{KIND_RETX, h, tx_next, '0, 1'b0});
                            tx_next = tx_next + 1'b1;
                        end
                    end
                end
            end
            default: begin
                clear_link();
            end
        endcase
        if (run.size() > 0)
            run[run.size()-1].last = 1'b1;
        foreach (run[i])
            due_results.push_back(run[i]);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_link_result want;
        if (!i_rst_n) begin
            clear_link();
            rtx_limit = MAX_RTX_RESET;
            due_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (due_results.size() == 0) begin
                    $error("unexpected result: kind %0d, label %0h",
                           i_m_tuser, i_m_tdata[2*LABEL_W-1:LABEL_W]);
                    mismatch_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("result_kind", int'(want.kind), int'(i_m_tuser));
                    check_field("out_handle", int'(want.handle),
                                int'(i_m_tdata[LABEL_W-1:0]));
                    check_field("out_label", int'(want.label),
                                int'(i_m_tdata[2*LABEL_W-1:LABEL_W]));
                    check_field("out_received_label", int'(want.rx_label),
                                int'(i_m_tdata[3*LABEL_W-1:2*LABEL_W]));
                    check_field("last_of_run", int'(want.last), int'(i_m_tlast));
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                rtx_limit = i_cfg_data;
            if (i_s_tvalid && i_s_tready)
                predict_request(i_s_tuser, i_s_tdata);
        end
        waiting_count = due_results.size();
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the link loss detection block. A checker module beside the
// block watches all three channels, predicts the results and counts mismatches; this
// module makes requests, moves the result ready line, and decides pass or fail.
module testbench;
    import lldr_pkg::*;

    localparam int RING_DEPTH    = 64;
    // The receiver holds off this long once, so that the block backs up into its input.
    localparam int HOLD_CYCLES   = 400;
    // A notification can walk 64 slots and the reset mode clears the ring one slot a
    // cycle; this margin covers any tail of work that produces no result.
    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_ITEMS   = 50;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic [DATA_W-1:0]  i_s_tdata;
    logic [MODE_W-1:0]  i_s_tuser;
    logic               o_m_tvalid;
    logic               i_m_tready;
    logic [DATA_W-1:0]  o_m_tdata;
    logic [KIND_W-1:0]  o_m_tuser;
    logic               o_m_tlast;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CNT_W-1:0]   i_cfg_data;

    int                 mismatches;
    int                 outstanding;
    int                 cycles = 0;
    // When steady is set neither side idles; squeeze asks the receiver for one long hold.
    logic               steady;
    logic               squeeze;
    // Rough view of the link, used only to shape requests into realistic sequences.
    logic [LABEL_W-1:0] tx_seen;
    logic [LABEL_W-1:0] rx_next;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    link_loss_detect_retransmit_top #(
        .RING_DEPTH (RING_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    lldr_label_checker #(
        .RING_DEPTH (RING_DEPTH)
    ) u_label_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_m_tuser     (o_m_tuser),
        .i_m_tlast     (o_m_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    function automatic logic [LABEL_W-1:0] rnd_label();
        return LABEL_W'($urandom);
    endfunction

    // A hung block must still end the run with a verdict.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Track the newest label the block handed out, so that notifications mostly
    // name ranges that are still held in the ring. Any reset starts it over.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready && i_s_tuser == MODE_RESET))
            tx_seen <= LABEL_RESET;
        else if (o_m_tvalid && i_m_tready && o_m_tuser != KIND_LOSS)
            tx_seen <= o_m_tdata[2*LABEL_W-1:LABEL_W] + 1'b1;
    end

    // Result side: random stalls, none while steady, and one long hold on request.
    initial begin
        bit held;
        held       = 1'b0;
        i_m_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (squeeze && !held) begin
                held = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_m_tready <= steady || $urandom_range(0, 99) >= 19;
            end
        end
    end

    // Offers one request and returns at the falling edge after it was taken. The valid
    // line is left high so that back-to-back requests keep it high without a glitch.
    task automatic push_req(logic [MODE_W-1:0] mode, logic [LABEL_W-1:0] handle, label,
                            rlabel);
        while (!steady && $urandom_range(0, 99) < 19) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= {rlabel, label, handle};
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        if (mode == MODE_RECV) begin
            rx_next = label + 1'b1;
        end else if (mode == MODE_RESET) begin
            rx_next = LABEL_RESET;
        end
    endtask

    task automatic write_max_rtx(logic [CNT_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Lets every predicted result come out, then leaves room for silent work.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Mostly well-formed traffic: sends, in-order arrivals and notifications over
    // recently sent labels. The rest is gaps, resyncs, wild ranges and resets.
    task automatic random_req();
        int                 pick, sub;
        logic [LABEL_W-1:0] handle, lo, hi;
        pick   = $urandom_range(0, 99);
        sub    = $urandom_range(0, 9);
        handle = rnd_label();
        lo     = rnd_label();
        hi     = rnd_label();
        if (pick < 40) begin
            push_req(MODE_SEND, handle, lo, hi);
        end else if (pick < 70) begin
            if (sub < 7)
                lo = rx_next;
            else if (sub == 7)
                lo = rx_next + LABEL_W'($urandom_range(1, 4));
            else if (sub == 8)
                lo = LABEL_RESET;
            push_req(MODE_RECV, handle, lo, hi);
        end else if (pick < 97) begin
            if (sub < 8) begin
                lo = tx_seen - LABEL_W'($urandom_range(0, 90));
                hi = lo + LABEL_W'($urandom_range(1, 70));
            end else if (sub == 8) begin
                hi = lo - LABEL_W'($urandom_range(0, 2));
            end
            push_req(MODE_NOTIFY, handle, lo, hi);
        end else begin
            push_req(MODE_RESET, handle, lo, hi);
        end
    endtask

    initial begin
        logic [CNT_W-1:0] limits [5];
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = MODE_SEND;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        steady      = 1'b0;
        squeeze     = 1'b0;
        rx_next     = LABEL_RESET;
        // Both extremes of the retry limit, then small and mid values.
        limits      = '{4'd0, 4'd15, 4'd1, CNT_W'($urandom_range(2, 14)), 4'd3};

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, run with the retry limit left at its reset value.
        // Sends with extreme handles fill labels 1 to 4.
        push_req(MODE_SEND, 16'h0000, rnd_label(), rnd_label());
        push_req(MODE_SEND, 16'hFFFF, rnd_label(), rnd_label());
        push_req(MODE_SEND, 16'hA5A5, rnd_label(), rnd_label());
        push_req(MODE_SEND, 16'h5A5A, rnd_label(), rnd_label());
        // In-order arrivals, a gap, a resync to the first label, a gap that leaves
        // the receiver expecting label zero, and the first label while at zero.
        push_req(MODE_RECV, rnd_label(), 16'd1, rnd_label());
        push_req(MODE_RECV, rnd_label(), 16'd2, rnd_label());
        push_req(MODE_RECV, rnd_label(), 16'd5, rnd_label());
        push_req(MODE_RECV, rnd_label(), 16'd1, rnd_label());
        push_req(MODE_RECV, rnd_label(), 16'hFFFF, rnd_label());
        push_req(MODE_RECV, rnd_label(), 16'd1, rnd_label());
        // Notifications: small ranges, an empty range, a reversed range, a range of
        // slots never written, the widest range (clamped) and a small range from label zero.
        push_req(MODE_NOTIFY, rnd_label(), 16'd1, 16'd3);
        push_req(MODE_NOTIFY, rnd_label(), 16'd1, 16'd5);
        push_req(MODE_NOTIFY, rnd_label(), 16'd3, 16'd3);
        push_req(MODE_NOTIFY, rnd_label(), 16'd10, 16'd4);
        push_req(MODE_NOTIFY, rnd_label(), 16'd20, 16'd30);
        push_req(MODE_NOTIFY, rnd_label(), 16'd0, 16'hFFFF);
        push_req(MODE_NOTIFY, rnd_label(), 16'd0, 16'd5);
        // Reset mode, then the link starts again from the first label.
        push_req(MODE_RESET, rnd_label(), rnd_label(), rnd_label());
        push_req(MODE_SEND, 16'h1234, rnd_label(), rnd_label());
        push_req(MODE_NOTIFY, rnd_label(), 16'd1, 16'd2);
        push_req(MODE_RECV, rnd_label(), 16'd1, rnd_label());
        settle();

        // Random phases, one retry limit each. The first one carries the long hold on
        // the result side; the third runs without any idling.
        for (int p = 0; p < 5; p++) begin
            write_max_rtx(limits[p]);
            if (p == 0)
                squeeze = 1'b1;
            steady = (p == 2);
            repeat (PHASE_ITEMS) random_req();
            settle();
        end

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
